@@ hw/rtl/u16u8_pkg.sv @@
`timescale 1ns / 1ps

package u16u8_pkg;

	localparam int CP_W  = 21;
	localparam int CNT_W = 3;

	localparam logic [CP_W-1:0]  REPL_CP   = 21'h00fffd;
	localparam logic [CP_W-1:0]  SUPP_BASE = 21'h010000;
	localparam logic [5:0]       HIGH_TAG  = 6'b110110;
	localparam logic [5:0]       LOW_TAG   = 6'b110111;
	localparam logic [CNT_W-1:0] REPL_LEN  = 3'd3;

	// one queued job: optional replacement char, then optional code point
	typedef struct packed {
		logic            repl;
		logic            has_cp;
		logic [CP_W-1:0] cp;
	} job_t;

	function automatic logic [CNT_W-1:0] cp_len(input logic [CP_W-1:0] cp);
		logic [CNT_W-1:0] len;
		if (cp <= 21'h00007f) begin
			len = 3'd1;
		end else if (cp <= 21'h0007ff) begin
			len = 3'd2;
		end else if (cp <= 21'h00ffff) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic [7:0] utf8_enc(input logic [CP_W-1:0] cp,
		input logic [CNT_W-1:0] len, input logic [CNT_W-1:0] k);
		logic [7:0] b;
		b = 8'h00;
		unique case (len)
			3'd1: b = {1'b0, cp[6:0]};
			3'd2: begin
				if (k == 3'd0) begin
					b = {3'b110, cp[10:6]};
				end else begin
					b = {2'b10, cp[5:0]};
				end
			end
			3'd3: begin
				case (k)
					3'd0:    b = {4'b1110, cp[15:12]};
					3'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (k)
					3'd0:    b = {5'b11110, cp[20:18]};
					3'd1:    b = {2'b10, cp[17:12]};
					3'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

@@ hw/rtl/u16u8_front.sv @@
`timescale 1ns / 1ps

module u16u8_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [15:0]           code_unit,
	output logic                  push,
	output u16u8_pkg::job_t       job
);

	logic       pend_valid_q;
	logic [9:0] pend_q;
	logic       is_high;
	logic       is_low;
	logic       pair;

	assign is_high = code_unit[15:10] == u16u8_pkg::HIGH_TAG;
	assign is_low  = code_unit[15:10] == u16u8_pkg::LOW_TAG;
	assign pair    = pend_valid_q && is_low;

	always_comb begin
		job.repl   = pend_valid_q && !is_low;
		job.has_cp = pair || !is_high;
		if (pair) begin
			job.cp = u16u8_pkg::SUPP_BASE + {1'b0, pend_q, code_unit[9:0]};
		end else if (is_low) begin
			job.cp = u16u8_pkg::REPL_CP;
		end else begin
			job.cp = {5'd0, code_unit};
		end
	end

	assign push = accept && (job.repl || job.has_cp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_valid_q <= is_high;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_high) begin
			pend_q <= code_unit[9:0];
		end
	end

endmodule

@@ hw/rtl/u16u8_fifo.sv @@
`timescale 1ns / 1ps

module u16u8_fifo #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u16u8_pkg::job_t push_job,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output u16u8_pkg::job_t head_job
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	u16u8_pkg::job_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

@@ hw/rtl/u16u8_back.sv @@
`timescale 1ns / 1ps

module u16u8_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  u16u8_pkg::job_t head_job,
	output logic            pop,
	output logic            out_valid,
	output logic [7:0]      out_byte,
	output logic            out_last,
	input  logic            out_ready
);

	logic [u16u8_pkg::CNT_W-1:0] idx_q;
	logic [u16u8_pkg::CNT_W-1:0] len;
	logic [u16u8_pkg::CNT_W-1:0] total;
	logic [u16u8_pkg::CNT_W-1:0] k_sel;
	logic [u16u8_pkg::CNT_W-1:0] len_sel;
	logic [u16u8_pkg::CP_W-1:0]  cp_sel;
	logic                        repl_phase;
	logic                        last;
	logic                        step;
	logic                        valid_q;
	logic [7:0]                  byte_q;
	logic                        last_q;

	assign len        = u16u8_pkg::cp_len(head_job.cp);
	assign total      = (head_job.repl ? u16u8_pkg::REPL_LEN : 3'd0)
		+ (head_job.has_cp ? len : 3'd0);
	assign repl_phase = head_job.repl && (idx_q < u16u8_pkg::REPL_LEN);
	assign cp_sel     = repl_phase ? u16u8_pkg::REPL_CP : head_job.cp;
	assign len_sel    = repl_phase ? u16u8_pkg::REPL_LEN : len;
	assign k_sel      = (head_job.repl && !repl_phase) ? idx_q - u16u8_pkg::REPL_LEN : idx_q;
	assign last       = idx_q == total - 3'd1;
	assign step       = head_valid && (!valid_q || out_ready);
	assign pop        = step && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (step) begin
				idx_q   <= last ? '0 : idx_q + 1'b1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (step) begin
			byte_q <= u16u8_pkg::utf8_enc(cp_sel, len_sel, k_sel);
			last_q <= last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

endmodule

@@ hw/rtl/utf16_to_utf8_transcoder.sv @@
// channel | dir | tdata                | tuser | tlast
// s_axis  | in  | [15:0] code_unit      | -     | -
// m_axis  | out | [7:0] utf8_byte      | -     | last_byte
//
// one utf-8 byte per cycle on the output while m_tready is high; an input unit
// yields 1 to 6 output bytes (0 for a held high surrogate), sent by the byte serializer.
// input is taken every cycle while the job queue (FIFO_DEPTH entries) has room.
// the first result byte passes through the job queue and the output register before it is valid.
// arst_n clears the pending surrogate, the queue and the output valid flag.
// output stalls fill the queue, then drop s_tready.
`timescale 1ns / 1ps

module utf16_to_utf8_transcoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] code_unit
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] utf8_byte
	output logic        m_tlast
);

	logic            accept;
	logic            push;
	logic            pop;
	logic            full;
	logic            head_valid;
	u16u8_pkg::job_t push_job;
	u16u8_pkg::job_t head_job;

	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.code_unit (s_tdata),
		.push      (push),
		.job       (push_job)
	);

	u16u8_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_byte   (m_tdata),
		.out_last   (m_tlast),
		.out_ready  (m_tready)
	);

endmodule
